// ===== rtl/udpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpc_pkg
// Shared types, constants and a ones'-complement helper for the UDP checksum
// check and generate core.
// ----------------------------------------------------------------------------
package udpc_pkg;

    localparam logic [16:0] MAX_PAYLOAD_BYTES = 17'd1480;
    localparam logic [15:0] UDP_PROTO_WORD    = 16'h0011;
    localparam logic [15:0] WORD_ONES         = 16'hffff;
    localparam logic [16:0] COUNT_MAX         = 17'h1ffff;
    localparam logic [16:0] MIN_DGRAM_BYTES   = 17'd8;
    localparam logic [16:0] LEN_WORD_OFFSET   = 17'd4;
    localparam logic [16:0] CKS_WORD_OFFSET   = 17'd6;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_LEN_MISM  = 3'd2,
        STATUS_CKS_ERR   = 3'd3,
        STATUS_LONG      = 3'd4
    } status_t;

    typedef enum logic {
        OP_VERIFY   = 1'b0,
        OP_GENERATE = 1'b1
    } op_t;

    // one accepted input beat
    typedef struct packed {
        logic        operation;
        logic        first;
        logic        last;
        logic [15:0] data_word;
        logic        odd_byte;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } beat_t;

    // datagram state after the current beat
    typedef struct packed {
        logic [15:0] running_sum;
        logic [16:0] byte_count;
        logic [15:0] length_field;
        logic        sum_field_nonzero;
        logic        mode;
    } acc_t;

    // end-around carry fold of a sum of up to seven 16-bit terms
    function automatic logic [15:0] fold_sum(input logic [18:0] s);
        logic [16:0] f;
        logic [15:0] r;
        f = {1'b0, s[15:0]} + {14'b0, s[18:16]};
        r = f[15:0] + {15'b0, f[16]};
        return r;
    endfunction

endpackage

// ===== rtl/udpc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpc_in_stage
// Input register: captures one beat and holds it until the datapath takes it.
// ----------------------------------------------------------------------------
module udpc_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_stall,
    input  udpc_pkg::beat_t beat,
    input  logic           advance,
    output logic           beat_valid,
    output udpc_pkg::beat_t beat_held
);
    import udpc_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    assign item_stall = valid_reg && !advance;
    assign load       = item_valid && !item_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= beat;
        end
    end

    assign beat_valid = valid_reg;
    assign beat_held  = beat_reg;

endmodule

// ===== rtl/udpc_sum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpc_sum
// Running ones'-complement sum, byte count and header field capture.
// ----------------------------------------------------------------------------
module udpc_sum
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  udpc_pkg::beat_t beat,
    output udpc_pkg::acc_t  acc_next
);
    import udpc_pkg::*;

    acc_t        acc_reg;
    acc_t        base;
    logic [15:0] word;
    logic [16:0] add_bytes;
    logic        off_len;
    logic        off_cks;
    logic [15:0] term_a;
    logic [15:0] term_b;
    logic [18:0] raw_sum;
    logic [17:0] count_sum;

    always_comb
    begin
        base = acc_reg;
        if (beat.first)
        begin
            base.running_sum       = '0;
            base.byte_count        = '0;
            base.length_field      = '0;
            base.sum_field_nonzero = 1'b0;
            base.mode              = beat.operation;
        end

        word      = beat.data_word;
        add_bytes = 17'd2;
        if (beat.last && beat.odd_byte)
        begin
            word      = {beat.data_word[15:8], 8'h00};
            add_bytes = 17'd1;
        end

        off_len = (base.byte_count == LEN_WORD_OFFSET);
        off_cks = (base.byte_count == CKS_WORD_OFFSET);

        if (base.mode == OP_VERIFY)
        begin
            term_a = word;
            term_b = off_len ? word : 16'h0000;
        end
        else
        begin
            term_a = (off_len || off_cks) ? 16'h0000 : word;
            term_b = 16'h0000;
        end

        if (beat.first)
        begin
            raw_sum = {3'b0, beat.src_addr[31:16]} + {3'b0, beat.src_addr[15:0]}
                    + {3'b0, beat.dst_addr[31:16]} + {3'b0, beat.dst_addr[15:0]}
                    + {3'b0, UDP_PROTO_WORD} + {3'b0, term_a} + {3'b0, term_b};
        end
        else
        begin
            raw_sum = {3'b0, base.running_sum} + {3'b0, term_a} + {3'b0, term_b};
        end

        count_sum = {1'b0, base.byte_count} + {1'b0, add_bytes};

        acc_next                   = base;
        acc_next.running_sum       = fold_sum(raw_sum);
        acc_next.byte_count        = count_sum[17] ? COUNT_MAX : count_sum[16:0];
        acc_next.length_field      = off_len ? word : base.length_field;
        acc_next.sum_field_nonzero = off_cks ? (word != 16'h0000) : base.sum_field_nonzero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (fire)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== rtl/udpc_result.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udpc_result
// Final checks on the last beat of a datagram and the result register.
// ----------------------------------------------------------------------------
module udpc_result
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  udpc_pkg::acc_t acc,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [2:0]     status,
    output logic [15:0]    checksum,
    output logic [15:0]    udp_length,
    output logic           checked
);
    import udpc_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    status_t     status_reg;
    status_t     status_next;
    logic [15:0] checksum_reg;
    logic [15:0] checksum_next;
    logic [15:0] udp_length_reg;
    logic [15:0] udp_length_next;
    logic        checked_reg;
    logic        checked_next;
    logic [15:0] verify_cks;
    logic [15:0] gen_fold;
    logic [15:0] gen_cks;

    always_comb
    begin
        verify_cks = ~acc.running_sum;
        gen_fold   = fold_sum({3'b0, acc.running_sum} + {3'b0, acc.byte_count[15:0]}
                              + {3'b0, acc.byte_count[15:0]});
        gen_cks    = (~gen_fold == 16'h0000) ? WORD_ONES : ~gen_fold;

        checked_next = 1'b0;
        if (acc.mode == OP_VERIFY)
        begin
            checksum_next   = verify_cks;
            udp_length_next = acc.length_field;
            if (acc.byte_count < MIN_DGRAM_BYTES)
            begin
                status_next = STATUS_SHORT;
            end
            else if (acc.byte_count < {1'b0, acc.length_field})
            begin
                status_next = STATUS_LEN_MISM;
            end
            else if (acc.sum_field_nonzero)
            begin
                checked_next = 1'b1;
                status_next  = (verify_cks != 16'h0000) ? STATUS_CKS_ERR : STATUS_OK;
            end
            else
            begin
                status_next = STATUS_OK;
            end
        end
        else
        begin
            udp_length_next = acc.byte_count[16] ? WORD_ONES : acc.byte_count[15:0];
            if (acc.byte_count < MIN_DGRAM_BYTES)
            begin
                status_next   = STATUS_SHORT;
                checksum_next = 16'h0000;
            end
            else if (acc.byte_count > MAX_PAYLOAD_BYTES)
            begin
                status_next   = STATUS_LONG;
                checksum_next = 16'h0000;
            end
            else
            begin
                status_next   = STATUS_OK;
                checksum_next = gen_cks;
            end
        end
    end

    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg     <= status_next;
            checksum_reg   <= checksum_next;
            udp_length_reg <= udp_length_next;
            checked_reg    <= checked_next;
        end
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign checksum     = checksum_reg;
    assign udp_length   = udp_length_reg;
    assign checked      = checked_reg;

endmodule

// ===== rtl/udp_checksum_check_and_generate_core.sv =====
`timescale 1ns / 1ps
// Takes one 16-bit datagram beat per clock while item_stall is low, with no
// gaps needed between datagrams. A beat passes an input register and then
// the sum/compare logic; the result for a last beat is loaded into the
// output register as that beat leaves the input register, and it holds
// there while result_stall is high. Beats that are not last keep flowing
// while a result waits; item_stall rises only when a last beat meets a
// full, stalled result register. The rate is set by the combinational
// ones'-complement adder that folds each word into the running sum.
// ----------------------------------------------------------------------------
// udp_checksum_check_and_generate_core
// UDP checksum verify / generate with IPv4 pseudo header.
// ----------------------------------------------------------------------------
module udp_checksum_check_and_generate_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic        first,
    input  logic        last,
    input  logic [15:0] data_word,
    input  logic        odd_byte,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [15:0] checksum,
    output logic [15:0] udp_length,
    output logic        checked
);
    import udpc_pkg::*;

    beat_t beat_in;
    beat_t beat_held;
    logic  beat_valid;
    logic  advance;
    logic  fire;
    acc_t  acc_next;

    assign beat_in.operation = operation;
    assign beat_in.first     = first;
    assign beat_in.last      = last;
    assign beat_in.data_word = data_word;
    assign beat_in.odd_byte  = odd_byte;
    assign beat_in.src_addr  = src_addr;
    assign beat_in.dst_addr  = dst_addr;

    // a last beat waits only while the result register is full and stalled
    assign advance = !(beat_held.last && result_valid && result_stall);
    assign fire    = beat_valid && advance;

    udpc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .beat       (beat_in),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat_held  (beat_held)
    );

    udpc_sum u_sum
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .beat     (beat_held),
        .acc_next (acc_next)
    );

    udpc_result u_result
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire && beat_held.last),
        .acc          (acc_next),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .checksum     (checksum),
        .udp_length   (udp_length),
        .checked      (checked)
    );

    a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a blocked result");

    a_long_zero_cks: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == STATUS_LONG || status == STATUS_SHORT) && !checked)
        |-> (checksum == 16'h0000 || udp_length == 16'h0000 || status == STATUS_SHORT))
        else $error("too-long datagram with nonzero checksum");

    a_checked_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && checked) |-> (status == STATUS_OK || status == STATUS_CKS_ERR))
        else $error("checked flag on a length error");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!$past(result_valid) && result_valid) |-> $past(fire && beat_held.last))
        else $error("result without a last beat");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UDP checksum check and generate core. Drives
// datagrams beat by beat (directed corner cases first, then random traffic
// with noise), predicts each result with a ones'-complement sum model and
// checks every accepted result field by field, under varying idle/stall.
// ----------------------------------------------------------------------------
module tb_top;

    import udpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_BEATS   = 200;
    localparam int MIN_DATAGRAMS  = 24;

    typedef enum int { LEN_EXACT, LEN_OVER, LEN_RANDOM } len_sel_t;
    typedef enum int { CKS_GOOD, CKS_ZERO, CKS_RANDOM } cks_sel_t;
    typedef enum int { FILL_RANDOM, FILL_ZERO, FILL_ONES } fill_t;

    typedef struct {
        status_t     status;
        logic [15:0] checksum;
        logic [15:0] udp_length;
        logic        checked;
    } udp_result_t;

    class udp_scoreboard;
        logic [15:0]  run_sum;
        logic [16:0]  count;
        logic [15:0]  len_word;
        logic         cks_nonzero;
        op_t          mode;
        udp_result_t  result_q[$];
        int           errors;

        function new();
            run_sum     = '0;
            count       = '0;
            len_word    = '0;
            cks_nonzero = 1'b0;
            mode        = OP_VERIFY;
            errors      = 0;
        endfunction

        static function logic [15:0] ones_add(logic [15:0] a, logic [15:0] b);
            logic [16:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'b0, s[16]};
        endfunction

        function void note_beat(logic op, logic fst, logic lst, logic [15:0] word,
                                logic odd, logic [31:0] src, logic [31:0] dst);
            logic [16:0] offset;
            logic [17:0] next_count;
            logic [15:0] w;
            logic [15:0] s;
            udp_result_t r;
            w = word;
            if (fst)
            begin
                s = ones_add(16'h0000, src[31:16]);
                s = ones_add(s, src[15:0]);
                s = ones_add(s, dst[31:16]);
                s = ones_add(s, dst[15:0]);
                run_sum     = ones_add(s, UDP_PROTO_WORD);
                count       = '0;
                len_word    = '0;
                cks_nonzero = 1'b0;
                mode        = op_t'(op);
            end
            offset = count;
            if (lst && odd)
            begin
                w = w & 16'hff00;
                next_count = {1'b0, count} + 18'd1;
            end
            else
            begin
                next_count = {1'b0, count} + 18'd2;
            end
            if (offset == LEN_WORD_OFFSET)
                len_word = w;
            if (offset == CKS_WORD_OFFSET)
                cks_nonzero = (w != 16'h0000);
            if (mode == OP_VERIFY)
            begin
                run_sum = ones_add(run_sum, w);
                if (offset == LEN_WORD_OFFSET)
                    run_sum = ones_add(run_sum, w);
            end
            else if (offset != LEN_WORD_OFFSET && offset != CKS_WORD_OFFSET)
            begin
                run_sum = ones_add(run_sum, w);
            end
            count = (next_count > {1'b0, COUNT_MAX}) ? COUNT_MAX : next_count[16:0];
            if (!lst)
                return;
            r.checked = 1'b0;
            if (mode == OP_VERIFY)
            begin
                r.checksum   = ~run_sum;
                r.udp_length = len_word;
                if (count < MIN_DGRAM_BYTES)
                    r.status = STATUS_SHORT;
                else if (count < {1'b0, len_word})
                    r.status = STATUS_LEN_MISM;
                else if (cks_nonzero)
                begin
                    r.checked = 1'b1;
                    r.status  = (r.checksum != 16'h0000) ? STATUS_CKS_ERR : STATUS_OK;
                end
                else
                    r.status = STATUS_OK;
            end
            else
            begin
                r.udp_length = count[16] ? WORD_ONES : count[15:0];
                if (count < MIN_DGRAM_BYTES)
                begin
                    r.status   = STATUS_SHORT;
                    r.checksum = 16'h0000;
                end
                else if (count > MAX_PAYLOAD_BYTES)
                begin
                    r.status   = STATUS_LONG;
                    r.checksum = 16'h0000;
                end
                else
                begin
                    s = ones_add(run_sum, count[15:0]);
                    s = ones_add(s, count[15:0]);
                    r.checksum = ~s;
                    if (r.checksum == 16'h0000)
                        r.checksum = WORD_ONES;
                    r.status = STATUS_OK;
                end
            end
            result_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [15:0] cks, logic [15:0] ulen,
                                   logic chkd);
            udp_result_t r;
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d checksum %h length %0d",
                         $time, st, cks, ulen);
                errors++;
                return;
            end
            r = result_q.pop_front();
            if (st !== r.status)
            begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, r.status, st);
                errors++;
            end
            if (cks !== r.checksum)
            begin
                $display("%0t: checksum mismatch, expected %h, actual %h",
                         $time, r.checksum, cks);
                errors++;
            end
            if (ulen !== r.udp_length)
            begin
                $display("%0t: udp_length mismatch, expected %0d, actual %0d",
                         $time, r.udp_length, ulen);
                errors++;
            end
            if (chkd !== r.checked)
            begin
                $display("%0t: checked mismatch, expected %0d, actual %0d",
                         $time, r.checked, chkd);
                errors++;
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    logic        operation;
    logic        first;
    logic        last;
    logic [15:0] data_word;
    logic        odd_byte;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        result_valid;
    logic        result_stall;
    logic [2:0]  status;
    logic [15:0] checksum;
    logic [15:0] udp_length;
    logic        checked;

    udp_scoreboard sb;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          beats_sent;
    int          dgrams_sent;
    int          quiet_cycles;

    udp_checksum_check_and_generate_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .operation    (operation),
        .first        (first),
        .last         (last),
        .data_word    (data_word),
        .odd_byte     (odd_byte),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .checksum     (checksum),
        .udp_length   (udp_length),
        .checked      (checked)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        result_stall <= (recv_stall_pct > 0) && ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(status, checksum, udp_length, checked);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic set_phase(int p);
        case (p)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 68;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 68;
            end
            default:
            begin
                send_idle_pct  = 37;
                recv_stall_pct = 37;
            end
        endcase
    endtask

    task automatic send_beat(logic op, logic fst, logic lst, logic [15:0] word, logic odd,
                             logic [31:0] src, logic [31:0] dst);
        @(negedge clk);
        while ((send_idle_pct > 0) && ($urandom_range(0, 99) < send_idle_pct))
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        first      <= fst;
        last       <= lst;
        data_word  <= word;
        odd_byte   <= odd;
        src_addr   <= src;
        dst_addr   <= dst;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_beat(op, fst, lst, word, odd, src, dst);
        beats_sent++;
    endtask

    task automatic send_datagram(op_t op, int nbytes, len_sel_t len_sel, cks_sel_t cks_sel,
                                 fill_t fill);
        logic [15:0] words[$];
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] s;
        logic [15:0] w;
        logic [16:0] over_len;
        int          nw;
        bit          odd;
        nw  = (nbytes + 1) / 2;
        odd = 1'(nbytes % 2);
        src = (fill == FILL_RANDOM) ? $urandom : (fill == FILL_ZERO) ? '0 : '1;
        dst = (fill == FILL_RANDOM) ? $urandom : (fill == FILL_ZERO) ? '0 : '1;
        for (int i = 0; i < nw; i++)
            words.push_back((fill == FILL_RANDOM) ? 16'($urandom) :
                            (fill == FILL_ZERO) ? 16'h0000 : 16'hffff);
        if (nw > 2)
        begin
            over_len = 17'(nbytes + 1 + $urandom_range(0, 20));
            case (len_sel)
                LEN_EXACT: words[2] = 16'(nbytes);
                LEN_OVER:  words[2] = over_len[16] ? 16'hffff : over_len[15:0];
                default:   words[2] = 16'($urandom);
            endcase
        end
        if (nw > 3 && op == OP_VERIFY)
        begin
            case (cks_sel)
                CKS_GOOD:
                begin
                    s = udp_scoreboard::ones_add(16'h0000, src[31:16]);
                    s = udp_scoreboard::ones_add(s, src[15:0]);
                    s = udp_scoreboard::ones_add(s, dst[31:16]);
                    s = udp_scoreboard::ones_add(s, dst[15:0]);
                    s = udp_scoreboard::ones_add(s, UDP_PROTO_WORD);
                    s = udp_scoreboard::ones_add(s, words[2]);
                    for (int i = 0; i < nw; i++)
                    begin
                        w = (i == 3) ? 16'h0000 : words[i];
                        if (i == nw - 1 && odd)
                            w = w & 16'hff00;
                        s = udp_scoreboard::ones_add(s, w);
                    end
                    words[3] = (s == 16'hffff) ? 16'hffff : ~s;
                end
                CKS_ZERO: words[3] = 16'h0000;
                default:  words[3] = 16'($urandom);
            endcase
        end
        for (int i = 0; i < nw; i++)
            send_beat((i == 0) ? op : 1'($urandom), i == 0, i == nw - 1, words[i],
                      (i == nw - 1) ? odd : 1'($urandom), src, dst);
        dgrams_sent++;
    endtask

    task automatic send_noise(int n);
        for (int i = 0; i < n; i++)
            send_beat(1'($urandom), $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0,
                      16'($urandom), 1'($urandom), $urandom, $urandom);
    endtask

    task automatic send_random_datagram();
        int       r;
        int       nbytes;
        op_t      op;
        len_sel_t len_sel;
        cks_sel_t cks_sel;
        fill_t    fill;
        op = op_t'($urandom_range(0, 1));
        r  = $urandom_range(0, 99);
        if (r < 8)
            nbytes = $urandom_range(1, 7);
        else
            nbytes = $urandom_range(8, 48);
        r = $urandom_range(0, 99);
        len_sel = (r < 75) ? LEN_EXACT : (r < 85) ? LEN_OVER : LEN_RANDOM;
        r = $urandom_range(0, 99);
        cks_sel = (r < 60) ? CKS_GOOD : (r < 75) ? CKS_ZERO : CKS_RANDOM;
        r = $urandom_range(0, 99);
        fill = (r < 90) ? FILL_RANDOM : (r < 95) ? FILL_ZERO : FILL_ONES;
        send_datagram(op, nbytes, len_sel, cks_sel, fill);
    endtask

    initial
    begin
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        operation      = 1'b0;
        first          = 1'b0;
        last           = 1'b0;
        data_word      = '0;
        odd_byte       = 1'b0;
        src_addr       = '0;
        dst_addr       = '0;
        result_stall   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        beats_sent     = 0;
        dgrams_sent    = 0;
        quiet_cycles   = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // beats with no first right after reset: no pseudo-header addresses
        send_beat(OP_GENERATE, 1'b0, 1'b0, 16'h1234, 1'b1, '1, '1);
        send_beat(OP_VERIFY, 1'b0, 1'b0, 16'hffff, 1'b0, '1, '1);
        send_beat(OP_VERIFY, 1'b0, 1'b1, 16'h8001, 1'b0, '1, '1);
        send_datagram(OP_VERIFY, 2, LEN_EXACT, CKS_GOOD, FILL_ONES);
        send_datagram(OP_GENERATE, 1, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_VERIFY, 6, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_VERIFY, 20, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_VERIFY, 21, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_VERIFY, 20, LEN_EXACT, CKS_ZERO, FILL_RANDOM);
        send_datagram(OP_VERIFY, 20, LEN_EXACT, CKS_RANDOM, FILL_RANDOM);
        send_datagram(OP_VERIFY, 16, LEN_OVER, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_VERIFY, 8, LEN_EXACT, CKS_GOOD, FILL_ONES);
        send_datagram(OP_VERIFY, 8, LEN_EXACT, CKS_GOOD, FILL_ZERO);
        send_datagram(OP_GENERATE, 7, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_GENERATE, 8, LEN_EXACT, CKS_GOOD, FILL_ZERO);
        send_datagram(OP_GENERATE, 9, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        send_datagram(OP_GENERATE, 1481, LEN_EXACT, CKS_GOOD, FILL_RANDOM);
        // continuation beats after a last extend the previous datagram
        send_beat(OP_VERIFY, 1'b0, 1'b0, 16'habcd, 1'b1, $urandom, $urandom);
        send_beat(OP_VERIFY, 1'b0, 1'b1, 16'h00ff, 1'b1, $urandom, $urandom);

        beats_sent  = 0;
        dgrams_sent = 0;
        while (beats_sent < RANDOM_BEATS || dgrams_sent < MIN_DATAGRAMS)
        begin
            set_phase((dgrams_sent / 6) % 4);
            if ($urandom_range(0, 99) < 10)
                send_noise($urandom_range(1, 6));
            else
                send_random_datagram();
        end

        set_phase(3);
        send_random_datagram();

        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
